// ===== sv/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcu_pkg - shared types and constants for the binomial coefficient unit
// Field widths, datapath widths and the divider status record.
// ----------------------------------------------------------------------------
package bcu_pkg;

    // Field widths
    localparam int SIZE_W    = 6;
    localparam int COEFF_W   = 60;

    // Running value times a 6-bit factor
    localparam int PROD_W    = COEFF_W + SIZE_W;

    // One quotient bit per divider step
    localparam int DIV_STEPS = PROD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== sv/bcu_divider.sv =====
// ----------------------------------------------------------------------------
// bcu_divider - radix-2 restoring divider
// Divides a PROD_W-bit dividend by a 6-bit divisor, one quotient bit per
// cycle. The sequencer only ever issues exact divisions.
// ----------------------------------------------------------------------------
module bcu_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bcu_pkg::PROD_W-1:0]    i_dividend,
    input  logic [bcu_pkg::SIZE_W-1:0]    i_divisor,
    output bcu_pkg::t_div_status          o_status,
    output logic [bcu_pkg::COEFF_W-1:0]   o_quotient
);
    import bcu_pkg::*;

    logic [PROD_W-1:0] r_quo, n_quo;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_dsr, n_dsr;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SIZE_W+1:0] w_trial;
    logic              w_fit;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {1'b0, r_rem, r_quo[PROD_W-1]} - {2'b00, r_dsr};
    assign w_fit   = ~w_trial[SIZE_W+1];

    // Load on start, then shift one quotient bit in per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[PROD_W-2:0], w_fit};
            n_rem = w_fit ? w_trial[SIZE_W-1:0] : {r_rem[SIZE_W-2:0], r_quo[PROD_W-1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control in reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo[COEFF_W-1:0];

`ifndef SYNTHESIS
    // A division is never issued by zero
    a_dsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_dsr != '0))
        else $error("divider running with zero divisor");

    // Every issued division is exact
    a_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem == '0))
        else $error("division left a remainder");

    // Quotient fits the coefficient width
    a_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_quo[PROD_W-1:COEFF_W] == '0))
        else $error("quotient overflows coefficient width");

    // Done follows the final step only
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

// ===== sv/binomial_coefficient_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_unit - exact binomial coefficient C(n, r)
// Sequencer, 60x6 multiplier and a single serial divider reused for every step.
// ----------------------------------------------------------------------------
// Pulse start with set_size (n) and pick_count (r) while busy is low; busy
// rises on the next cycle and stays high until the result is delivered.
// The coefficient appears on o_coefficient for exactly one cycle with
// o_valid high and cannot be stalled, so capture it then. For r = 0, r > n
// or n above MAX_SET_SIZE the answer is ready in the cycle after the transfer.
// Otherwise the value is built as value * (n - r + i) / i for i = 1..r, each
// step passing through the multiply state, the radix-2 divider's serial loop
// and a hand-back once the divider reports done. The divider's
// one-bit-per-cycle loop sets the overall latency.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit #(
    parameter int MAX_SET_SIZE = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [bcu_pkg::SIZE_W-1:0]    i_set_size,
    input  logic [bcu_pkg::SIZE_W-1:0]    i_pick_count,
    output logic                          busy,
    output logic                          o_valid,
    output logic [bcu_pkg::COEFF_W-1:0]   o_coefficient
);
    import bcu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_set, n_set;
    logic [SIZE_W-1:0]  r_pick, n_pick;
    logic [SIZE_W-1:0]  r_idx, n_idx;
    logic [COEFF_W-1:0] r_value, n_value;
    logic [SIZE_W-1:0]  w_factor;
    logic [PROD_W-1:0]  w_prod;
    logic               w_accept;
    logic               w_div_start;
    logic               w_trivial;
    t_div_status        w_div_st;
    logic [COEFF_W-1:0] w_quot;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_trivial = (i_set_size > SIZE_W'(MAX_SET_SIZE)) || (i_pick_count > i_set_size)
                       || (i_pick_count == '0);

    // Factor n - r + i stays within 1..n
    assign w_factor    = r_set - r_pick + r_idx;
    assign w_prod      = PROD_W'(r_value) * PROD_W'(w_factor);
    assign w_div_start = (r_state == S_MUL);

    bcu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_idx),
        .o_status   (w_div_st),
        .o_quotient (w_quot)
    );

    // Sequence the steps: multiply, divide, advance i or deliver the result
    always_comb begin
        n_state = r_state;
        n_set   = r_set;
        n_pick  = r_pick;
        n_idx   = r_idx;
        n_value = r_value;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_set  = i_set_size;
                    n_pick = i_pick_count;
                    n_idx  = SIZE_W'(1);
                    if (w_trivial) begin
                        n_value = (i_pick_count == '0) && (i_set_size <= SIZE_W'(MAX_SET_SIZE))
                                  ? COEFF_W'(1) : '0;
                        n_state = S_OUT;
                    end else begin
                        n_value = COEFF_W'(1);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_st.done) begin
                    n_value = w_quot;
                    if (r_idx == r_pick) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state in reset; operands and value need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_set   <= n_set;
        r_pick  <= n_pick;
        r_idx   <= n_idx;
        r_value <= n_value;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_coefficient = r_value;

`ifndef SYNTHESIS
    // A transfer always makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    // Result strobe lasts one cycle
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // Divider hands back only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_st.done |-> (r_state == S_DIV))
        else $error("divider done outside the divide state");

    // Pick count above set size yields zero
    a_zero_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_pick > r_set)) |-> (o_coefficient == '0))
        else $error("non-zero result for pick count above set size");

    // Step index never passes the pick count while working
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_DIV)) |-> (r_idx <= r_pick && r_idx != '0))
        else $error("step index out of range");
`endif

endmodule
